// ===== rtl/cubic_bezier_point_evaluator_defines.svh =====
// ----------------------------------------------------------------------------
// Cubic Bezier point evaluator - assertion macros
// Shared concurrent check forms used by the RTL of the evaluator.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_POINT_EVALUATOR_DEFINES_SVH
`define CUBIC_BEZIER_POINT_EVALUATOR_DEFINES_SVH

// same-cycle implication, masked during reset
`define CBEZ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbez: same-cycle check failed");

// next-cycle implication, masked during reset
`define CBEZ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbez: next-cycle check failed");

`endif

// ===== rtl/cbez_pkg.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier point evaluator - package
// Widths, pipeline geometry and shared types of the evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbez_pkg;

   localparam int K_W        = 10;  // step index
   localparam int COORD_W    = 12;  // control point and result coordinate
   localparam int W_W        = 3 * K_W;  // Bernstein weight, sum is S^3
   localparam int PROD_W     = W_W + COORD_W + 1;
   localparam int MAG_W      = PROD_W - 1;
   localparam int QUO_W      = COORD_W;
   localparam int DIV_BITS   = 2;   // quotient bits resolved per divider stage
   localparam int DIV_STAGES = QUO_W / DIV_BITS;
   localparam int NSTAGE     = 7 + DIV_STAGES;  // total register stages
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 2 * COORD_W;
   localparam int NUM_REGS   = 8;
   localparam int IDX_W      = 3;

   typedef logic [W_W-1:0]            weight_type;
   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic [IDX_W-1:0] {
      REG_P0_X = 3'd0,
      REG_P0_Y = 3'd1,
      REG_P1_X = 3'd2,
      REG_P1_Y = 3'd3,
      REG_P2_X = 3'd4,
      REG_P2_Y = 3'd5,
      REG_P3_X = 3'd6,
      REG_P3_Y = 3'd7
   } reg_index_type;

endpackage

`default_nettype wire

// ===== rtl/cbez_weights.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier point evaluator - weight generator
// Two stages: saturate k and form the squares, then the four cubic weights.
// ----------------------------------------------------------------------------
`default_nettype none

module cbez_weights #(
   parameter int STEPS = 1000
) (
   input  logic                                clock,
   input  logic [1:0]                          en,
   input  logic [cbez_pkg::K_W-1:0]            step_index,
   output cbez_pkg::weight_type [3:0]          weight
);

   localparam int KW = cbez_pkg::K_W;
   localparam int WW = cbez_pkg::W_W;
   localparam logic [KW-1:0] S_K = KW'(STEPS);

   logic [KW-1:0]   k_sat;
   logic [KW-1:0]   u_val;
   logic [KW-1:0]   k_ff, k_in;
   logic [KW-1:0]   u_ff, u_in;
   logic [2*KW-1:0] uu_ff, uu_in;
   logic [2*KW-1:0] uk_ff, uk_in;
   logic [2*KW-1:0] kk_ff, kk_in;
   logic [WW-1:0]   t1;
   logic [WW-1:0]   t2;
   cbez_pkg::weight_type [3:0] w_ff, w_in;

   always_comb begin
      k_sat = (step_index > S_K) ? S_K : step_index;
      u_val = S_K - k_sat;
      k_in  = k_sat;
      u_in  = u_val;
      uu_in = (2*KW)'(u_val) * (2*KW)'(u_val);
      uk_in = (2*KW)'(u_val) * (2*KW)'(k_sat);
      kk_in = (2*KW)'(k_sat) * (2*KW)'(k_sat);
   end

   // times three by shift and add; every weight is bounded by S^3
   always_comb begin
      t1      = WW'(uu_ff) * WW'(k_ff);
      t2      = WW'(uk_ff) * WW'(k_ff);
      w_in[0] = WW'(uu_ff) * WW'(u_ff);
      w_in[1] = WW'({t1, 1'b0} + {1'b0, t1});
      w_in[2] = WW'({t2, 1'b0} + {1'b0, t2});
      w_in[3] = WW'(kk_ff) * WW'(k_ff);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         k_ff  <= k_in;
         u_ff  <= u_in;
         uu_ff <= uu_in;
         uk_ff <= uk_in;
         kk_ff <= kk_in;
      end
      if (en[1]) begin
         w_ff <= w_in;
      end
   end

   assign weight = w_ff;

endmodule

`default_nettype wire

// ===== rtl/cbez_combine.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier point evaluator - coordinate combiner
// Weighted products, two-level sum, then sign and magnitude of the numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module cbez_combine (
   input  logic                              clock,
   input  logic [3:0]                        en,
   input  cbez_pkg::weight_type [3:0]        weight,
   input  cbez_pkg::coord_type  [3:0]        coord,
   output logic [cbez_pkg::MAG_W-1:0]        mag,
   output logic                              neg
);

   localparam int PW = cbez_pkg::PROD_W;
   localparam int MW = cbez_pkg::MAG_W;
   localparam int WW = cbez_pkg::W_W;

   logic signed [WW:0]   ws     [4];
   logic signed [PW-1:0] prod_ff[4];
   logic signed [PW-1:0] prod_in[4];
   logic signed [PW-1:0] s01_ff, s01_in;
   logic signed [PW-1:0] s23_ff, s23_in;
   logic signed [PW-1:0] num_ff, num_in;
   logic signed [PW-1:0] num_neg;
   logic [PW-1:0]        abs_val;
   logic [MW-1:0]        mag_ff, mag_in;
   logic                 neg_ff, neg_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ws[i]      = $signed({1'b0, weight[i]});
         prod_in[i] = ws[i] * $signed(coord[i]);
      end
   end

   assign s01_in  = prod_ff[0] + prod_ff[1];
   assign s23_in  = prod_ff[2] + prod_ff[3];
   assign num_in  = s01_ff + s23_ff;
   assign num_neg = -num_ff;
   assign neg_in  = num_ff[PW-1];
   assign abs_val = neg_in ? num_neg : num_ff;
   assign mag_in  = abs_val[MW-1:0];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
      if (en[1]) begin
         s01_ff <= s01_in;
         s23_ff <= s23_in;
      end
      if (en[2]) begin
         num_ff <= num_in;
      end
      if (en[3]) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   assign mag = mag_ff;
   assign neg = neg_ff;

endmodule

`default_nettype wire

// ===== rtl/cbez_divider.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier point evaluator - constant divider
// Pipelined restoring division of the magnitude by STEPS^3, two quotient
// bits per stage, sign carried alongside for truncation toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cbez_divider #(
   parameter int STEPS = 1000
) (
   input  logic                                   clock,
   input  logic [cbez_pkg::DIV_STAGES-1:0]        en,
   input  logic [cbez_pkg::MAG_W-1:0]             mag,
   input  logic                                   neg,
   output logic [cbez_pkg::QUO_W-1:0]             quo,
   output logic                                   quo_neg
);

   localparam int MW  = cbez_pkg::MAG_W;
   localparam int QW  = cbez_pkg::QUO_W;
   localparam int DB  = cbez_pkg::DIV_BITS;
   localparam int NDS = cbez_pkg::DIV_STAGES;
   localparam logic [MW-1:0] DEN = MW'(STEPS * STEPS * STEPS);

   logic [MW-1:0] rem_ff[NDS-1];
   logic [QW-1:0] quo_ff[NDS];
   logic          neg_ff[NDS];

   for (genvar j = 0; j < NDS; j++) begin : g_stage
      logic [MW-1:0] rem_src;
      logic [QW-1:0] quo_src;
      logic          neg_src;
      logic [MW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (j == 0) begin : g_first
         assign rem_src = mag;
         assign quo_src = '0;
         assign neg_src = neg;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign quo_src = quo_ff[j-1];
         assign neg_src = neg_ff[j-1];
      end

      always_comb begin
         rem_in = rem_src;
         quo_in = quo_src;
         for (int b = 0; b < DB; b++) begin
            if (rem_in >= (DEN << (QW - 1 - j * DB - b))) begin
               rem_in = rem_in - (DEN << (QW - 1 - j * DB - b));
               quo_in[QW - 1 - j * DB - b] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            quo_ff[j] <= quo_in;
            neg_ff[j] <= neg_src;
         end
      end

      // last remainder is not needed
      if (j < NDS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en[j]) begin
               rem_ff[j] <= rem_in;
            end
         end
      end
   end

   assign quo     = quo_ff[NDS-1];
   assign quo_neg = neg_ff[NDS-1];

endmodule

`default_nettype wire

// ===== rtl/cubic_bezier_point_evaluator.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier point evaluator - top level
// Control point registers, pipeline valid/advance control and output stage.
// ----------------------------------------------------------------------------
// Usage:
//   Write the four control points through the csr_ channel (index 0..7 is
//   p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y); csr_ready is always
//   high. Write only while no beat is in flight.
//   Each req_ beat carries a step index k (saturated at STEPS); each rsp_
//   beat returns the curve point at t = k/STEPS, truncated toward zero,
//   plus an in-frame flag. One result per request, in order.
//   Throughput: one beat per cycle while the rsp_ side is not stalled,
//   through the 13-stage pipeline (weights, products, sums, magnitude,
//   six 2-bit divider stages, output register).
//   A stalled rsp_ side holds the result; upstream stages keep filling any
//   empty slots, so req_tready drops only once every stage holds a beat.
//   Reset clears all valid bits and the control points to zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_bezier_point_evaluator_defines.svh"

module cubic_bezier_point_evaluator #(
   parameter int STEPS        = 1000,
   parameter int FRAME_WIDTH  = 1024,
   parameter int FRAME_HEIGHT = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [cbez_pkg::REQ_DATA_W-1:0]      req_tdata,   // [9:0] step_index
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cbez_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [11:0] point_x, [23:12] point_y
   output logic                                 rsp_tuser,   // [0] in_frame
   // control point writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cbez_pkg::IDX_W-1:0]           csr_index,
   input  logic [cbez_pkg::COORD_W-1:0]         csr_wdata
);

   localparam int NS  = cbez_pkg::NSTAGE;
   localparam int CW  = cbez_pkg::COORD_W;
   localparam int QW  = cbez_pkg::QUO_W;
   localparam int NDS = cbez_pkg::DIV_STAGES;
   localparam logic [CW-1:0] FW = CW'(FRAME_WIDTH);
   localparam logic [CW-1:0] FH = CW'(FRAME_HEIGHT);
   localparam logic [QW-1:0] QUO_MAX = QW'(1) << (QW - 1);

   cbez_pkg::coord_type cp_ff[cbez_pkg::NUM_REGS];

   logic [NS-1:0] valid_ff, valid_in;
   logic [NS-1:0] valid_prev;
   logic [NS-1:0] adv;

   cbez_pkg::weight_type [3:0] weight;
   cbez_pkg::coord_type  [3:0] ctrl_x, ctrl_y;
   logic [cbez_pkg::MAG_W-1:0] mag_x, mag_y;
   logic                       neg_x, neg_y;
   logic [QW-1:0]              quo_x, quo_y;
   logic                       qneg_x, qneg_y;

   logic [CW-1:0] x_ff, x_in;
   logic [CW-1:0] y_ff, y_in;
   logic          frame_ff, frame_in;

   // ---------------- control points ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbez_pkg::NUM_REGS; i++) begin
            cp_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         cp_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      ctrl_x[0] = cp_ff[cbez_pkg::REG_P0_X];
      ctrl_x[1] = cp_ff[cbez_pkg::REG_P1_X];
      ctrl_x[2] = cp_ff[cbez_pkg::REG_P2_X];
      ctrl_x[3] = cp_ff[cbez_pkg::REG_P3_X];
      ctrl_y[0] = cp_ff[cbez_pkg::REG_P0_Y];
      ctrl_y[1] = cp_ff[cbez_pkg::REG_P1_Y];
      ctrl_y[2] = cp_ff[cbez_pkg::REG_P2_Y];
      ctrl_y[3] = cp_ff[cbez_pkg::REG_P3_Y];
   end

   // ---------------- pipeline control ----------------
   // a stage moves when the sink takes a beat or any slot at or after it is empty
   for (genvar i = 0; i < NS; i++) begin : g_adv
      assign adv[i] = rsp_tready | ~(&valid_ff[NS-1:i]);
   end

   assign valid_prev = {valid_ff[NS-2:0], req_tvalid};
   assign valid_in   = (adv & valid_prev) | (~adv & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = adv[0];

   // ---------------- datapath ----------------
   cbez_weights #(
      .STEPS(STEPS)
   ) u_weights (
      .clock      (clock),
      .en         (adv[1:0]),
      .step_index (req_tdata[cbez_pkg::K_W-1:0]),
      .weight     (weight)
   );

   cbez_combine u_combine_x (
      .clock  (clock),
      .en     (adv[5:2]),
      .weight (weight),
      .coord  (ctrl_x),
      .mag    (mag_x),
      .neg    (neg_x)
   );

   cbez_combine u_combine_y (
      .clock  (clock),
      .en     (adv[5:2]),
      .weight (weight),
      .coord  (ctrl_y),
      .mag    (mag_y),
      .neg    (neg_y)
   );

   cbez_divider #(
      .STEPS(STEPS)
   ) u_divider_x (
      .clock   (clock),
      .en      (adv[5+NDS:6]),
      .mag     (mag_x),
      .neg     (neg_x),
      .quo     (quo_x),
      .quo_neg (qneg_x)
   );

   cbez_divider #(
      .STEPS(STEPS)
   ) u_divider_y (
      .clock   (clock),
      .en      (adv[5+NDS:6]),
      .mag     (mag_y),
      .neg     (neg_y),
      .quo     (quo_y),
      .quo_neg (qneg_y)
   );

   // ---------------- output stage ----------------
   always_comb begin
      x_in     = qneg_x ? (~quo_x + QW'(1)) : quo_x;
      y_in     = qneg_y ? (~quo_y + QW'(1)) : quo_y;
      frame_in = !x_in[CW-1] && ({1'b0, x_in[CW-2:0]} < FW) &&
                 !y_in[CW-1] && ({1'b0, y_in[CW-2:0]} < FH);
   end

   always_ff @(posedge clock) begin
      if (adv[NS-1]) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         frame_ff <= frame_in;
      end
   end

   assign rsp_tvalid = valid_ff[NS-1];
   assign rsp_tdata  = {y_ff, x_ff};
   assign rsp_tuser  = frame_ff;

   // ---------------- checks ----------------
   `CBEZ_ASSERT_IMP(a_ready_when_sink_ready, clock, reset, rsp_tready, req_tready)
   `CBEZ_ASSERT_NXT(a_accept_fills_first, clock, reset, req_tvalid && req_tready, valid_ff[0])
   `CBEZ_ASSERT_IMP(a_frame_implies_nonneg, clock, reset, rsp_tvalid && rsp_tuser, !rsp_tdata[CW-1] && !rsp_tdata[2*CW-1])
   `CBEZ_ASSERT_IMP(a_quotient_in_range, clock, reset, valid_ff[NS-2], quo_x <= QUO_MAX && quo_y <= QUO_MAX)

endmodule

`default_nettype wire
